>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Every macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define WPP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the condition holds, the consequence holds at the next clock edge.
`define WPP_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/wpp_pkg.sv
`default_nettype none

package wpp_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ROW0_LO   = 3'd0,
		REG_ROW0_HI   = 3'd1,
		REG_ROW1_LO   = 3'd2,
		REG_ROW1_HI   = 3'd3,
		REG_ROW3_LO   = 3'd4,
		REG_ROW3_HI   = 3'd5,
		REG_VIEWPORT  = 3'd6
	} cfg_reg_t;

	localparam int WORD_W = 32;

	localparam logic [63:0] RST_ROW0_LO  = 64'd65536;
	localparam logic [63:0] RST_ROW0_HI  = 64'd0;
	localparam logic [63:0] RST_ROW1_LO  = 64'd281474976710656;
	localparam logic [63:0] RST_ROW1_HI  = 64'd0;
	localparam logic [63:0] RST_ROW3_LO  = 64'd0;
	localparam logic [63:0] RST_ROW3_HI  = 64'd281474976710656;
	localparam logic [31:0] RST_VIEWPORT = 32'd70780800;

	// Sign and special-case flags that travel with a point through the divider.
	typedef struct packed {
		logic behind;
		logic neg_x;
		logic neg_y;
		logic zero_x;
		logic zero_y;
		logic ovf_x;
		logic ovf_y;
	} div_side_t;

endpackage

`default_nettype wire

>>> hw/rtl/wpp_dot.sv
`default_nettype none

module wpp_dot import wpp_pkg::*; #(
	parameter int F = 16,
	parameter int CW = 65 - F
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [WORD_W-1:0] px,
	input  wire logic signed [WORD_W-1:0] py,
	input  wire logic signed [WORD_W-1:0] pz,
	input  wire logic [63:0]            row_lo [3],
	input  wire logic [63:0]            row_hi [3],
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [CW-1:0]        sum [3]
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;
	logic signed [WORD_W-1:0] pt [3];
	logic signed [WORD_W-1:0] coef [3][3];
	logic signed [WORD_W-1:0] bias [3];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [CW-1:0] sum_s2 [3];

	assign en_s2 = !v_s2 || out_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s2;

	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = row_lo[r][31:0];
			coef[r][1] = row_lo[r][63:32];
			coef[r][2] = row_hi[r][31:0];
			bias[r] = row_hi[r][63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= coef[r][c] * pt[c];
				end
			end
		end
	end

	// Each product is floored to the coordinate format before the sum.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= CW'(prod_s1[r][0] >>> F) + CW'(prod_s1[r][1] >>> F)
					+ CW'(prod_s1[r][2] >>> F) + CW'(bias[r]);
			end
		end
	end

	assign sum = sum_s2;

endmodule

`default_nettype wire

>>> hw/rtl/wpp_div.sv
`default_nettype none

`include "assert_macros.svh"

module wpp_div import wpp_pkg::*; #(
	parameter int F = 16,
	parameter int CW = 65 - F
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [CW-1:0]     cx,
	input  wire logic signed [CW-1:0]     cy,
	input  wire logic signed [CW-1:0]     w,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [WORD_W-1:0]      nx,
	output logic signed [WORD_W-1:0]      ny,
	output logic                          behind
);

	localparam int AW = CW - 1;
	localparam int NW = AW + F;
	localparam int QW = WORD_W;
	localparam int SW = NW + QW;
	localparam int NS = QW + 2;
	localparam logic signed [CW-1:0] THR = CW'(((1 << F) + 500) / 1000);

	logic [NS-1:0] v;
	logic [NS-1:0] en;
	logic [NW-1:0] rx [0:QW];
	logic [NW-1:0] ry [0:QW];
	logic [QW-1:0] qx [0:QW];
	logic [QW-1:0] qy [0:QW];
	logic [AW-1:0] bq [0:QW];
	div_side_t sd [0:QW];
	logic [AW-1:0] ax, ay, bw, bz;
	div_side_t side_in;
	logic signed [WORD_W-1:0] nx_q, ny_q;
	logic behind_q;

	function automatic logic signed [WORD_W-1:0] finish(
		input logic [QW-1:0] q, input logic ovf, input logic neg, input logic zero);
		logic [QW:0] m;
		m = ovf ? {1'b1, {QW{1'b0}}} : {1'b0, q};
		if (zero) return '0;
		if (!neg) return (m > {2'b00, {(QW-1){1'b1}}}) ? {1'b0, {(QW-1){1'b1}}} : m[QW-1:0];
		return (m > {2'b01, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : -m[QW-1:0];
	endfunction

	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = out_ready || !(&v[NS-1:k]);
	end
	assign in_ready = en[0];
	assign out_valid = v[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) v[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v[k] <= v[k-1];
			end
		end
	end

	// Magnitudes, signs and the integer-part overflow test.
	always_comb begin
		ax = cx[CW-1] ? AW'(-cx) : AW'(cx);
		ay = cy[CW-1] ? AW'(-cy) : AW'(cy);
		bw = w[CW-1] ? AW'(-w) : AW'(w);
		bz = (bw == '0) ? AW'(1) : bw;
		side_in.behind = w < THR;
		side_in.neg_x = (cx[CW-1] ^ w[CW-1]) ^ side_in.behind;
		side_in.neg_y = (cy[CW-1] ^ w[CW-1]) ^ side_in.behind;
		side_in.zero_x = cx == '0;
		side_in.zero_y = cy == '0;
		side_in.ovf_x = SW'(ax) >= (SW'(bz) << (QW - F));
		side_in.ovf_y = SW'(ay) >= (SW'(bz) << (QW - F));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rx[0] <= NW'(ax) << F;
			ry[0] <= NW'(ay) << F;
			qx[0] <= '0;
			qy[0] <= '0;
			bq[0] <= bz;
			sd[0] <= side_in;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [SW-1:0] sh;
		logic gx, gy;
		assign sh = SW'(bq[k-1]) << (QW - k);
		assign gx = SW'(rx[k-1]) >= sh;
		assign gy = SW'(ry[k-1]) >= sh;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rx[k] <= gx ? rx[k-1] - NW'(sh) : rx[k-1];
				ry[k] <= gy ? ry[k-1] - NW'(sh) : ry[k-1];
				qx[k] <= {qx[k-1][QW-2:0], gx};
				qy[k] <= {qy[k-1][QW-2:0], gy};
				bq[k] <= bq[k-1];
				sd[k] <= sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			nx_q <= finish(qx[QW], sd[QW].ovf_x, sd[QW].neg_x, sd[QW].zero_x);
			ny_q <= finish(qy[QW], sd[QW].ovf_y, sd[QW].neg_y, sd[QW].zero_y);
			behind_q <= sd[QW].behind;
		end
	end

	assign nx = nx_q;
	assign ny = ny_q;
	assign behind = behind_q;

	`WPP_ASSERT(a_ovf_sat, (v[QW] && sd[QW].ovf_x && !sd[QW].zero_x) |-> (finish(qx[QW], 1'b1, sd[QW].neg_x, 1'b0) == {1'b0, {(QW-1){1'b1}}} || finish(qx[QW], 1'b1, sd[QW].neg_x, 1'b0) == {1'b1, {(QW-1){1'b0}}}), "overflowed quotient not saturated")
	`WPP_ASSERT_NEXT(a_hold, (v[0] && !en[0]), (v[0] && $stable(bq[0])), "stalled divider entry lost its divisor")

endmodule

`default_nettype wire

>>> hw/rtl/wpp_view.sv
`default_nettype none

module wpp_view import wpp_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [WORD_W-1:0] nx,
	input  wire logic signed [WORD_W-1:0] ny,
	input  wire logic                    behind,
	input  wire logic [15:0]             wd,
	input  wire logic [15:0]             ht,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [WORD_W-1:0]     sx,
	output logic signed [WORD_W-1:0]     sy,
	output logic                         behind_o,
	output logic                         on_o
);

	localparam int MW = WORD_W + 17;
	localparam int XW = MW + 1;

	logic v_s1, v_s2, en_s1, en_s2;
	logic signed [MW-1:0] mx_s1, my_s1;
	logic behind_s1;
	logic signed [XW-1:0] wsc, hsc, one, x, y;
	logic signed [WORD_W-1:0] sx_s2, sy_s2;
	logic behind_s2, on_s2;

	function automatic logic signed [WORD_W-1:0] sat(input logic signed [XW-1:0] a);
		if (a > $signed(XW'({1'b0, {(WORD_W-1){1'b1}}}))) return {1'b0, {(WORD_W-1){1'b1}}};
		if (a < -$signed(XW'({1'b1, {(WORD_W-1){1'b0}}}))) return {1'b1, {(WORD_W-1){1'b0}}};
		return a[WORD_W-1:0];
	endfunction

	assign en_s2 = !v_s2 || out_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1 <= nx * $signed({1'b0, wd});
			my_s1 <= ny * $signed({1'b0, ht});
			behind_s1 <= behind;
		end
	end

	// Both sums are exact and then halved with floor.
	always_comb begin
		wsc = $signed(XW'(wd) << F);
		hsc = $signed(XW'(ht) << F);
		one = $signed(XW'(1) << F);
		x = (wsc + XW'(mx_s1) + one) >>> 1;
		y = (hsc - XW'(my_s1) - one) >>> 1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sx_s2 <= sat(x);
			sy_s2 <= sat(y);
			behind_s2 <= behind_s1;
			on_s2 <= !(x > wsc || x < 0 || y > hsc || y < 0 || behind_s1);
		end
	end

	assign sx = sx_s2;
	assign sy = sy_s2;
	assign behind_o = behind_s2;
	assign on_o = on_s2;

endmodule

`default_nettype wire

>>> hw/rtl/world_point_projector_top.sv
// Pipeline: 2 dot-product stages, 34 divider stages and 2 viewport stages.
// Throughput: one point per cycle while m_tready is high; a stalled output
// holds only the stages that are full.
// Reset (arst_n, asynchronous, active low) empties the pipeline and loads the
// identity-like matrix and a 1920 x 1080 viewport.
`default_nettype none

`include "assert_macros.svh"

module world_point_projector_top import wpp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input point stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // screen_x [31:0], screen_y [63:32]
	output logic [1:0]       m_tuser,   // behind_camera [0], on_screen [1]
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [63:0] cfg_wdata
);

	localparam int F = COORD_FRAC_BITS;
	localparam int CW = 65 - F;

	// Matrix rows 0, 1 and 3 plus the viewport size; the stages read them directly.
	// Writes must come only while the pipeline is empty; nothing in the block checks this.
	logic [63:0] row_lo_q [3];
	logic [63:0] row_hi_q [3];
	logic [31:0] viewport_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_lo_q[0] <= RST_ROW0_LO;
			row_hi_q[0] <= RST_ROW0_HI;
			row_lo_q[1] <= RST_ROW1_LO;
			row_hi_q[1] <= RST_ROW1_HI;
			row_lo_q[2] <= RST_ROW3_LO;
			row_hi_q[2] <= RST_ROW3_HI;
			viewport_q <= RST_VIEWPORT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ROW0_LO:  row_lo_q[0] <= cfg_wdata;
				REG_ROW0_HI:  row_hi_q[0] <= cfg_wdata;
				REG_ROW1_LO:  row_lo_q[1] <= cfg_wdata;
				REG_ROW1_HI:  row_hi_q[1] <= cfg_wdata;
				REG_ROW3_LO:  row_lo_q[2] <= cfg_wdata;
				REG_ROW3_HI:  row_hi_q[2] <= cfg_wdata;
				REG_VIEWPORT: viewport_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// Dot products give clip x, clip y and w.
	logic dot_valid, dot_ready;
	logic signed [CW-1:0] clip [3];

	wpp_dot #(.F(F), .CW(CW)) u_dot (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.px(s_tdata[31:0]), .py(s_tdata[63:32]), .pz(s_tdata[95:64]),
		.row_lo(row_lo_q), .row_hi(row_hi_q),
		.out_valid(dot_valid), .out_ready(dot_ready),
		.sum(clip)
	);

	// Perspective divide: one restoring step per stage for both coordinates.
	logic div_valid, div_ready, div_behind;
	logic signed [WORD_W-1:0] nx, ny;

	wpp_div #(.F(F), .CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dot_valid), .in_ready(dot_ready),
		.cx(clip[0]), .cy(clip[1]), .w(clip[2]),
		.out_valid(div_valid), .out_ready(div_ready),
		.nx(nx), .ny(ny), .behind(div_behind)
	);

	// Viewport mapping; its last stage is the output register.
	logic signed [WORD_W-1:0] sx, sy;
	logic behind_o, on_o;

	wpp_view #(.F(F)) u_view (
		.clk(clk), .arst_n(arst_n),
		.in_valid(div_valid), .in_ready(div_ready),
		.nx(nx), .ny(ny), .behind(div_behind),
		.wd(viewport_q[15:0]), .ht(viewport_q[31:16]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sx(sx), .sy(sy), .behind_o(behind_o), .on_o(on_o)
	);

	assign m_tdata = {sy, sx};
	assign m_tuser = {on_o, behind_o};

	// A point behind the camera is never reported on screen.
	`WPP_ASSERT(a_behind_off, (m_tvalid && m_tuser[0]) |-> !m_tuser[1], "behind point on screen")
	// Input backpressure only arises when every stage is full and the output stalls.
	`WPP_ASSERT(a_full_stall, !s_tready |-> (m_tvalid && !m_tready), "input stalled with room")

endmodule

`default_nettype wire
